### rtl/core/b2f_pkg.sv
// Package for the 2D Burgers FTCS stencil: shared types, register indexes
// and the saturation helper. No dependencies.
package b2f_pkg;

	localparam int DEF_MAX_COLS  = 1024;
	localparam int DEF_MAX_ROWS  = 1024;
	localparam int DEF_FRAC_BITS = 16;

	localparam int CFG_W   = 31;
	localparam int VAL_W   = 32;
	localparam int IDX_W   = 10;
	localparam int CIDX_W  = 3;
	localparam int GSIZE_W = 11;

	typedef enum logic [CIDX_W-1:0] {
		REG_TIME_STEP   = 3'd0,
		REG_INV_DX      = 3'd1,
		REG_INV_DY      = 3'd2,
		REG_SPACING_SQ  = 3'd3,
		REG_VISCOSITY   = 3'd4,
		REG_SHOCK_COEFF = 3'd5,
		REG_GRID_COLS   = 3'd6,
		REG_GRID_ROWS   = 3'd7
	} cfg_reg_t;

	// Coefficient set, unsigned Q format
	typedef struct packed {
		logic [CFG_W-1:0] dt;
		logic [CFG_W-1:0] inv_dx;
		logic [CFG_W-1:0] inv_dy;
		logic [CFG_W-1:0] sq_sum;
		logic [CFG_W-1:0] nu;
		logic [CFG_W-1:0] cq;
	} coef_t;

	// Five-point stencil of one field: n/s along x, w/e along y
	typedef struct packed {
		logic signed [VAL_W-1:0] n;
		logic signed [VAL_W-1:0] w;
		logic signed [VAL_W-1:0] c;
		logic signed [VAL_W-1:0] s;
		logic signed [VAL_W-1:0] e;
	} point5_t;

	typedef struct packed {
		point5_t u;
		point5_t v;
	} stencil_t;

	localparam logic signed [67:0] S32_HI = 68'sh0_7FFF_FFFF;
	localparam logic signed [67:0] S32_LO = -68'sh0_8000_0000;

	function automatic logic signed [31:0] sat32(input logic signed [67:0] x);
		if (x > S32_HI)
			return 32'sh7FFF_FFFF;
		if (x < S32_LO)
			return 32'sh8000_0000;
		return 32'(x);
	endfunction

endpackage

### rtl/core/burgers_2d_ftcs_stencil.sv
// Top level of the 2D Burgers FTCS stencil: stream ports, config registers,
// line-store memories, window and raster counters. Uses b2f_pkg, b2f_core.
//
// Usage:
//  - Points enter on s_axis in row-major raster order, one beat per point:
//    grid_rows rows of grid_cols points. u in tdata[31:0], v in tdata[63:32].
//  - When point (r, c) arrives with r >= 2 and c >= 2, the interior point
//    (r-1, c-1) is updated and leaves on m_axis; boundary points give no beat.
//    tlast marks the last interior point of the grid.
//  - Throughput: one point at a time. A boundary point goes through the
//    line-store read and window update only; an interior point goes on to
//    21 multiply/writeback steps on the one shared multiplier, then the
//    hand-off into the output register.
//  - A finished beat waits in the output register; the next input point is
//    taken meanwhile. If the output is still full when the next result is
//    ready, the sequencer holds that result and s_axis_tready stays low.
//  - Reset: counters, window and config return to defaults; line stores are
//    not cleared (only rows already written in the grid are read).
//  - Config writes via cfg_we/cfg_index/cfg_data, only while idle.
module burgers_2d_ftcs_stencil #(
	parameter int MAX_COLS  = b2f_pkg::DEF_MAX_COLS,
	parameter int MAX_ROWS  = b2f_pkg::DEF_MAX_ROWS,
	parameter int FRAC_BITS = b2f_pkg::DEF_FRAC_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// slave: [31:0] u_value, [63:32] v_value
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [63:0]                 s_axis_tdata,
	// master: [31:0] u_new, [63:32] v_new, [73:64] row_index, [83:74] col_index
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [87:0]                 m_axis_tdata,
	output logic                        m_axis_tlast,
	input  logic                        cfg_we,
	input  logic [b2f_pkg::CIDX_W-1:0]  cfg_index,
	input  logic [b2f_pkg::CFG_W-1:0]   cfg_data
);
	import b2f_pkg::*;

	localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int AW    = CW + 1;
	localparam int DEPTH = 2 ** AW;

	typedef enum logic [1:0] {T_IDLE, T_LOAD, T_CALC} tstate_t;

	tstate_t              state_q;
	coef_t                coef_q;
	logic [GSIZE_W-1:0]   grid_cols_q, grid_rows_q;
	logic [CW-1:0]        col_q;
	logic [RW-1:0]        row_q;

	logic signed [31:0]   u_mem [DEPTH];
	logic signed [31:0]   v_mem [DEPTH];
	logic signed [31:0]   u_top_q, u_mid_q, v_top_q, v_mid_q;
	logic signed [31:0]   in_u_q, in_v_q;
	// window per field: [0] top row c-1, [1] mid c-2, [2] mid c-1, [3] cur c-1
	logic signed [31:0]   uw_q [4];
	logic signed [31:0]   vw_q [4];
	stencil_t             st_q;

	logic [IDX_W-1:0]     row_idx_q, col_idx_q;
	logic                 last_q;
	logic                 out_valid_q;
	logic [87:0]          out_data_q;
	logic                 out_last_q;

	logic                 in_acc, row_end, grid_end, interior, core_done, take;
	logic [31:0]          cols_eff, rows_eff;
	logic [AW-1:0]        cur_addr, prev_addr;
	logic signed [31:0]   core_u, core_v;

	// config port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.dt     <= 31'd655;
			coef_q.inv_dx <= 31'd65536;
			coef_q.inv_dy <= 31'd65536;
			coef_q.sq_sum <= 31'd131072;
			coef_q.nu     <= 31'd655;
			coef_q.cq     <= 31'd0;
			grid_cols_q   <= 11'd1024;
			grid_rows_q   <= 11'd1024;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_TIME_STEP:   coef_q.dt     <= cfg_data;
				REG_INV_DX:      coef_q.inv_dx <= cfg_data;
				REG_INV_DY:      coef_q.inv_dy <= cfg_data;
				REG_SPACING_SQ:  coef_q.sq_sum <= cfg_data;
				REG_VISCOSITY:   coef_q.nu     <= cfg_data;
				REG_SHOCK_COEFF: coef_q.cq     <= cfg_data;
				REG_GRID_COLS:   grid_cols_q   <= cfg_data[GSIZE_W-1:0];
				REG_GRID_ROWS:   grid_rows_q   <= cfg_data[GSIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// grid size clamped to [3, MAX]
	always_comb begin
		if (32'(grid_cols_q) < 32'd3)
			cols_eff = 32'd3;
		else if (32'(grid_cols_q) > 32'(MAX_COLS))
			cols_eff = 32'(MAX_COLS);
		else
			cols_eff = 32'(grid_cols_q);
		if (32'(grid_rows_q) < 32'd3)
			rows_eff = 32'd3;
		else if (32'(grid_rows_q) > 32'(MAX_ROWS))
			rows_eff = 32'(MAX_ROWS);
		else
			rows_eff = 32'(grid_rows_q);
	end

	assign in_acc    = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == T_IDLE);
	// rows alternate between the two halves of each line store by parity
	assign cur_addr  = {row_q[0], col_q};
	assign prev_addr = {~row_q[0], col_q};
	assign row_end   = (32'(col_q) + 32'd1) >= cols_eff;
	assign grid_end  = row_end && ((32'(row_q) + 32'd1) >= rows_eff);
	assign interior  = (32'(row_q) >= 32'd2) && (32'(col_q) >= 32'd2);
	assign take      = (state_q == T_CALC) && core_done && (!out_valid_q || m_axis_tready);

	// line stores: two reads at accept, write-back of the new point in T_LOAD
	always_ff @(posedge clk) begin
		if (in_acc) begin
			u_top_q <= u_mem[cur_addr];
			u_mid_q <= u_mem[prev_addr];
			in_u_q  <= s_axis_tdata[31:0];
		end
		if (state_q == T_LOAD)
			u_mem[cur_addr] <= in_u_q;
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			v_top_q <= v_mem[cur_addr];
			v_mid_q <= v_mem[prev_addr];
			in_v_q  <= s_axis_tdata[63:32];
		end
		if (state_q == T_LOAD)
			v_mem[cur_addr] <= in_v_q;
	end

	// stencil snapshot and result position, taken before the window shifts
	always_ff @(posedge clk) begin
		if (state_q == T_LOAD) begin
			st_q.u    <= '{n: uw_q[0], w: uw_q[1], c: uw_q[2], s: uw_q[3], e: u_mid_q};
			st_q.v    <= '{n: vw_q[0], w: vw_q[1], c: vw_q[2], s: vw_q[3], e: v_mid_q};
			row_idx_q <= IDX_W'(32'(row_q) - 32'd1);
			col_idx_q <= IDX_W'(32'(col_q) - 32'd1);
			last_q    <= grid_end;
		end
	end

	// control: state, counters, window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
			col_q   <= '0;
			row_q   <= '0;
			for (int k = 0; k < 4; k++) begin
				uw_q[k] <= '0;
				vw_q[k] <= '0;
			end
		end else begin
			case (state_q)
				T_IDLE: if (in_acc) state_q <= T_LOAD;
				T_LOAD: begin
					uw_q[0] <= u_top_q; uw_q[1] <= uw_q[2];
					uw_q[2] <= u_mid_q; uw_q[3] <= in_u_q;
					vw_q[0] <= v_top_q; vw_q[1] <= vw_q[2];
					vw_q[2] <= v_mid_q; vw_q[3] <= in_v_q;
					if (row_end) begin
						col_q <= '0;
						row_q <= grid_end ? '0 : RW'(32'(row_q) + 32'd1);
					end else begin
						col_q <= CW'(32'(col_q) + 32'd1);
					end
					state_q <= interior ? T_CALC : T_IDLE;
				end
				T_CALC: if (take) state_q <= T_IDLE;
				default: state_q <= T_IDLE;
			endcase
		end
	end

	b2f_core #(
		.FRAC_BITS(FRAC_BITS)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.start (state_q == T_LOAD && interior),
		.ack   (take),
		.st    (st_q),
		.coef  (coef_q),
		.done  (core_done),
		.u_new (core_u),
		.v_new (core_v)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (take)
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_data_q <= {4'd0, col_idx_q, row_idx_q, core_v, core_u};
			out_last_q <= last_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

endmodule

### rtl/core/b2f_core.sv
// Arithmetic sequencer: one shared 33x33 multiplier stepped through a fixed
// op list for one stencil point. Depends on b2f_pkg.
module b2f_core #(
	parameter int FRAC_BITS = b2f_pkg::DEF_FRAC_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                ack,
	input  b2f_pkg::stencil_t   st,
	input  b2f_pkg::coef_t      coef,
	output logic                done,
	output logic signed [31:0]  u_new,
	output logic signed [31:0]  v_new
);
	import b2f_pkg::*;

	typedef enum logic [4:0] {
		OP_I2X, OP_I2Y, OP_CQS,
		OP_UDX, OP_UDY, OP_VDX, OP_VDY,
		OP_UXX, OP_UYY, OP_VXX, OP_VYY,
		OP_ART, OP_ND,
		OP_A0, OP_A1, OP_A2, OP_A3,
		OP_P0, OP_P1, OP_Q0, OP_Q1
	} op_t;

	localparam int NUM_OPS = 21;

	typedef enum logic [1:0] {C_IDLE, C_MUL, C_WB, C_DONE} cstate_t;

	cstate_t                state_q;
	op_t                    step_q;
	logic signed [31:0]     res_q [NUM_OPS];
	logic signed [65:0]     prod_q;
	logic                   sh1_q;

	logic signed [32:0]     a_op, b_op;
	logic                   sh1;
	logic signed [65:0]     shifted;
	logic signed [31:0]     wb_val;
	logic signed [31:0]     div, nu_tot;

	function automatic logic signed [32:0] ucfg(input logic [CFG_W-1:0] x);
		return $signed({2'b00, x});
	endfunction

	function automatic logic signed [32:0] d2(input logic signed [31:0] hi,
		input logic signed [31:0] mid, input logic signed [31:0] lo);
		logic signed [34:0] s;
		s = 35'(hi) - (35'(mid) <<< 1) + 35'(lo);
		return 33'(sat32(68'(s)));
	endfunction

	function automatic logic signed [32:0] add_sat(input logic signed [31:0] a,
		input logic signed [31:0] b);
		return 33'(sat32(68'(a) + 68'(b)));
	endfunction

	assign div    = sat32(68'(res_q[OP_UDX]) + 68'(res_q[OP_VDY]));
	assign nu_tot = sat32(68'(ucfg(coef.nu)) + 68'(res_q[OP_ART]));

	always_comb begin
		a_op = '0;
		b_op = '0;
		sh1  = 1'b0;
		case (step_q)
			OP_I2X: begin a_op = ucfg(coef.inv_dx); b_op = ucfg(coef.inv_dx); end
			OP_I2Y: begin a_op = ucfg(coef.inv_dy); b_op = ucfg(coef.inv_dy); end
			OP_CQS: begin a_op = ucfg(coef.cq); b_op = ucfg(coef.sq_sum); end
			OP_UDX: begin
				a_op = 33'(st.u.s) - 33'(st.u.n); b_op = ucfg(coef.inv_dx); sh1 = 1'b1;
			end
			OP_UDY: begin
				a_op = 33'(st.u.e) - 33'(st.u.w); b_op = ucfg(coef.inv_dy); sh1 = 1'b1;
			end
			OP_VDX: begin
				a_op = 33'(st.v.s) - 33'(st.v.n); b_op = ucfg(coef.inv_dx); sh1 = 1'b1;
			end
			OP_VDY: begin
				a_op = 33'(st.v.e) - 33'(st.v.w); b_op = ucfg(coef.inv_dy); sh1 = 1'b1;
			end
			OP_UXX: begin a_op = d2(st.u.s, st.u.c, st.u.n); b_op = 33'(res_q[OP_I2X]); end
			OP_UYY: begin a_op = d2(st.u.e, st.u.c, st.u.w); b_op = 33'(res_q[OP_I2Y]); end
			OP_VXX: begin a_op = d2(st.v.s, st.v.c, st.v.n); b_op = 33'(res_q[OP_I2X]); end
			OP_VYY: begin a_op = d2(st.v.e, st.v.c, st.v.w); b_op = 33'(res_q[OP_I2Y]); end
			OP_ART: begin
				// artificial viscosity only under compression
				a_op = 33'(res_q[OP_CQS]);
				b_op = div[31] ? -33'(div) : '0;
			end
			OP_ND:  begin a_op = 33'(nu_tot); b_op = ucfg(coef.dt); end
			OP_A0:  begin a_op = 33'(st.u.c); b_op = 33'(res_q[OP_UDX]); end
			OP_A1:  begin a_op = 33'(st.v.c); b_op = 33'(res_q[OP_UDY]); end
			OP_A2:  begin a_op = 33'(st.u.c); b_op = 33'(res_q[OP_VDX]); end
			OP_A3:  begin a_op = 33'(st.v.c); b_op = 33'(res_q[OP_VDY]); end
			OP_P0:  begin a_op = ucfg(coef.dt); b_op = add_sat(res_q[OP_A0], res_q[OP_A1]); end
			OP_P1:  begin a_op = ucfg(coef.dt); b_op = add_sat(res_q[OP_A2], res_q[OP_A3]); end
			OP_Q0:  begin
				a_op = 33'(res_q[OP_ND]); b_op = add_sat(res_q[OP_UXX], res_q[OP_UYY]);
			end
			OP_Q1:  begin
				a_op = 33'(res_q[OP_ND]); b_op = add_sat(res_q[OP_VXX], res_q[OP_VYY]);
			end
			default: begin a_op = '0; b_op = '0; end
		endcase
	end

	// floor shift: arithmetic right shift rounds toward minus infinity
	assign shifted = sh1_q ? (prod_q >>> (FRAC_BITS + 1)) : (prod_q >>> FRAC_BITS);
	assign wb_val  = sat32(68'(shifted));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			step_q  <= OP_I2X;
		end else begin
			case (state_q)
				C_IDLE: if (start) begin
					step_q  <= OP_I2X;
					state_q <= C_MUL;
				end
				C_MUL: state_q <= C_WB;
				C_WB: begin
					if (step_q == OP_Q1) begin
						state_q <= C_DONE;
					end else begin
						step_q  <= op_t'(step_q + 5'd1);
						state_q <= C_MUL;
					end
				end
				C_DONE: if (ack) state_q <= C_IDLE;
				default: state_q <= C_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == C_MUL) begin
			prod_q <= a_op * b_op;
			sh1_q  <= sh1;
		end
		if (state_q == C_WB)
			res_q[step_q] <= wb_val;
	end

	assign done  = (state_q == C_DONE);
	assign u_new = sat32(68'(st.u.c) - 68'(res_q[OP_P0]) + 68'(res_q[OP_Q0]));
	assign v_new = sat32(68'(st.v.c) - 68'(res_q[OP_P1]) + 68'(res_q[OP_Q1]));

endmodule
